### sv/ir_pulse_width_direction_estimator_core_defines.svh
// ----------------------------------------------------------------------------
// IR pulse width direction estimator: assertion macros
// Concurrent assertion helpers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_DIRECTION_ESTIMATOR_CORE_DEFINES_SVH
`define IR_PULSE_WIDTH_DIRECTION_ESTIMATOR_CORE_DEFINES_SVH

// check outside reset
`define IRPWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs during reset
`define IRPWD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/irpwd_pkg.sv
// ----------------------------------------------------------------------------
// IR pulse width direction estimator package
// Shared constants, register indexes and pipeline types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package irpwd_pkg;

  localparam int NUM_SENSORS = 4;
  localparam int WIDTH_W     = 13;

  typedef logic [WIDTH_W-1:0] width_t;

  localparam logic [0:0]  CFG_TIMEOUT   = 1'b0;
  localparam logic [0:0]  CFG_LIMIT     = 1'b1;

  localparam logic [11:0] TIMEOUT_RESET = 12'd870;
  localparam logic [5:0]  LIMIT_RESET   = 6'd50;
  localparam logic [5:0]  LIMIT_MAX     = 6'd50;
  localparam logic [6:0]  CENTER        = 7'd50;

  // spread at or above 51 * 500 always saturates the offset
  localparam logic [24:0] SAT_SPREAD    = 25'd25500;
  // floor(y / 125) = (y * RECIP_125) >> 20, exact for y below 21399
  localparam logic [13:0] RECIP_125     = 14'd8389;

  typedef enum logic [1:0] {
    DIR_CENTER,
    DIR_LEFT,
    DIR_RIGHT
  } dir_code_t;

  typedef struct packed {
    logic [2:0] best_idx;
    width_t     best_w;
    dir_code_t  code;
  } side_t;

endpackage

### sv/irpwd_lane.sv
// ----------------------------------------------------------------------------
// IR pulse width capture lane
// Edge detection, tick counter, width latch and timeout for one receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irpwd_lane
  import irpwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic        level,
  input  logic [11:0] timeout,
  output width_t      width
);

  width_t cnt_r, cnt_nxt;
  width_t width_r, width_nxt;
  logic   last_r;

  always_comb begin
    width_t inc;
    inc       = (last_r && !level) ? '0 : cnt_r + 1'b1;
    cnt_nxt   = inc;
    width_nxt = (!last_r && level) ? inc : width_r;
    if (inc > {1'b0, timeout}) begin
      cnt_nxt   = '0;
      width_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      width_r <= '0;
      last_r  <= 1'b1;
    end else if (load) begin
      cnt_r   <= cnt_nxt;
      width_r <= width_nxt;
      last_r  <= level;
    end
  end

  assign width = width_r;

endmodule

### sv/irpwd_merge.sv
// ----------------------------------------------------------------------------
// IR pulse width merge pipeline
// Strongest lane, variance of the widths and direction, over five stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irpwd_merge
  import irpwd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  output logic                        s1_ready,
  input  width_t [NUM_SENSORS-1:0]    widths,
  input  logic [5:0]                  offset_limit,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [2:0] strongest_sensor, [15:3] strongest_width,
  // [40:16] width_spread, [47:41] direction
  output logic [47:0]                 out_tdata
);

  logic v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6     = !v6_r || out_tready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v3_r || rdy3 ? (!v2_r || rdy3) : !v2_r;
  assign s1_ready = rdy2;

  // stage 2: strongest lane, mean, pair compare
  width_t [NUM_SENSORS-1:0] w2_r;
  width_t                   mean2_r, mean2_nxt;
  side_t                    side2_r, side2_nxt;

  always_comb begin
    logic [14:0] sum;
    logic [13:0] left, right;
    logic        all_nz;
    sum       = '0;
    all_nz    = 1'b1;
    side2_nxt = '{best_idx: 3'd0, best_w: '0, code: DIR_CENTER};
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sum = sum + 15'(widths[i]);
      if (widths[i] > side2_nxt.best_w) begin
        side2_nxt.best_w   = widths[i];
        side2_nxt.best_idx = 3'(i + 1);
      end
      if (widths[i] == '0) all_nz = 1'b0;
    end
    mean2_nxt = sum[14:2];
    left      = 14'(widths[0]) + 14'(widths[1]);
    right     = 14'(widths[2]) + 14'(widths[3]);
    if (all_nz && left > right)      side2_nxt.code = DIR_LEFT;
    else if (all_nz && left < right) side2_nxt.code = DIR_RIGHT;
    else                             side2_nxt.code = DIR_CENTER;
  end

  // stage 3: squared deviations, one multiplier per lane
  logic [25:0] sq3_r [NUM_SENSORS];
  logic [25:0] sq3_nxt [NUM_SENSORS];
  side_t       side3_r;

  always_comb begin
    width_t d;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      d          = (w2_r[i] >= mean2_r) ? w2_r[i] - mean2_r : mean2_r - w2_r[i];
      sq3_nxt[i] = 26'(d) * 26'(d);
    end
  end

  // stage 4: sum of squares and variance
  logic [24:0] spread4_r, spread4_nxt;
  side_t       side4_r;

  always_comb begin
    logic [27:0] acc;
    acc = '0;
    for (int i = 0; i < NUM_SENSORS; i++) acc = acc + 28'(sq3_r[i]);
    spread4_nxt = acc[26:2];
  end

  // stage 5: spread / 500 by reciprocal
  logic [24:0] spread5_r;
  logic [5:0]  q5_r, q5_nxt;
  logic        sat5_r, sat5_nxt;
  side_t       side5_r;

  always_comb begin
    logic [26:0] prod;
    sat5_nxt = spread4_r >= SAT_SPREAD;
    prod     = 27'(spread4_r[14:2]) * 27'(RECIP_125);
    q5_nxt   = prod[25:20];
  end

  // stage 6: offset clamp and direction into the output register
  logic [47:0] data6_r, data6_nxt;

  always_comb begin
    logic [5:0] lim, step;
    logic [6:0] dir;
    lim  = (offset_limit > LIMIT_MAX) ? LIMIT_MAX : offset_limit;
    step = (sat5_r || q5_r > lim) ? lim : q5_r;
    unique case (side5_r.code)
      DIR_LEFT:  dir = CENTER - {1'b0, step};
      DIR_RIGHT: dir = CENTER + {1'b0, step};
      default:   dir = CENTER;
    endcase
    data6_nxt = {dir, spread5_r, side5_r.best_w, side5_r.best_idx};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= s1_valid;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid) begin
      w2_r    <= widths;
      mean2_r <= mean2_nxt;
      side2_r <= side2_nxt;
    end
    if (rdy3 && v2_r) begin
      sq3_r   <= sq3_nxt;
      side3_r <= side2_r;
    end
    if (rdy4 && v3_r) begin
      spread4_r <= spread4_nxt;
      side4_r   <= side3_r;
    end
    if (rdy5 && v4_r) begin
      spread5_r <= spread4_r;
      q5_r      <= q5_nxt;
      sat5_r    <= sat5_nxt;
      side5_r   <= side4_r;
    end
    if (rdy6 && v5_r) begin
      data6_r <= data6_nxt;
    end
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = data6_r;

endmodule

### sv/ir_pulse_width_direction_estimator_core.sv
// ----------------------------------------------------------------------------
// IR pulse width direction estimator core
// Four capture lanes feed a five-stage merge pipeline that gives the
// strongest receiver, the width variance and a direction value per tick.
// ----------------------------------------------------------------------------
// An accepted tick is registered in the lanes and v1_r, then in merge stages 2 to 6.
// Throughput: one tick per cycle; the lane counters and the merge stages
// each take a new transaction every cycle, stalling only on out_tready.
// Reset (synchronous, rst_n low): counters and widths cleared, levels idle
// high, registers back to timeout 870 and limit 50, pipeline emptied.
`timescale 1ns / 1ps

module ir_pulse_width_direction_estimator_core
  import irpwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] sensor_levels, [7:4] zero
  input  logic [7:0]  in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] strongest_sensor, [15:3] strongest_width,
  // [40:16] width_spread, [47:41] direction
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [11:0] cfg_wdata
);

  logic [11:0]              timeout_r;
  logic [5:0]               limit_r;
  logic                     v1_r;
  logic                     s1_ready;
  logic                     accept;
  width_t [NUM_SENSORS-1:0] widths;

  assign in_tready = !v1_r || s1_ready;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      limit_r   <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_LIMIT:   limit_r   <= cfg_wdata[5:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    irpwd_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .load    (accept),
      .level   (in_tdata[g]),
      .timeout (timeout_r),
      .width   (widths[g])
    );
  end

  irpwd_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_valid     (v1_r),
    .s1_ready     (s1_ready),
    .widths       (widths),
    .offset_limit (limit_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

### sv/irpwd_checker.sv
// ----------------------------------------------------------------------------
// IR pulse width direction estimator checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ir_pulse_width_direction_estimator_core_defines.svh"

module irpwd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  `IRPWD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `IRPWD_ASSERT(a_drain_ready, out_tvalid && out_tready |-> in_tready, "input blocked on drain")
  `IRPWD_ASSERT(a_best_zero, out_tvalid |-> ((out_tdata[2:0] == 3'd0) == (out_tdata[15:3] == 13'd0)), "strongest index and width disagree")
  `IRPWD_ASSERT(a_dir_center, out_tvalid && out_tdata[47:41] != 7'd50 |-> out_tdata[2:0] != 3'd0, "offset with no width")
  `IRPWD_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind ir_pulse_width_direction_estimator_core irpwd_checker u_irpwd_checker (.*);

### dv/ir_pulse_width_direction_estimator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse width direction estimator core: stream-level test
// Drives tick transactions of four receiver levels, tracks lane counters and
// widths alongside the block, and checks every estimate field by field under
// several register settings and stall patterns on both sides.
// ----------------------------------------------------------------------------

module ir_pulse_width_direction_estimator_core_test;
  import irpwd_pkg::*;

  localparam int SPREAD_STEP = 500;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [2:0]  sensor;
    logic [12:0] width;
    logic [24:0] spread;
    logic [6:0]  dir;
  } estimate_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h0F;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [0:0]  cfg_idx    = CFG_TIMEOUT;
  logic [11:0] cfg_wdata  = '0;

  logic [3:0]  tick_q[$];
  estimate_t   estimate_q[$];
  estimate_t   want;

  logic [12:0] lane_count [NUM_SENSORS];
  logic [12:0] lane_width [NUM_SENSORS];
  logic        lane_level [NUM_SENSORS];
  logic [11:0] model_timeout;
  logic [5:0]  model_limit;

  logic        gen_level [NUM_SENSORS];
  int          gen_left  [NUM_SENSORS];

  int send_idle  = 0;
  int recv_idle  = 0;
  int mismatches = 0;
  int cycles     = 0;

  ir_pulse_width_direction_estimator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic estimate_t estimate_tick(input logic [3:0] levels);
    estimate_t   r;
    logic [12:0] best_w;
    logic [2:0]  best_n;
    logic [31:0] total;
    logic [31:0] mean;
    logic [63:0] acc;
    logic [63:0] d;
    logic [31:0] spread;
    logic [31:0] step;
    logic [31:0] lim;
    logic [31:0] left;
    logic [31:0] right;
    logic        all_nz;
    best_w = '0;
    best_n = '0;
    total  = '0;
    acc    = '0;
    all_nz = 1'b1;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (lane_level[i] && !levels[i])
        lane_count[i] = '0;
      else
        lane_count[i] = lane_count[i] + 13'd1;
      if (!lane_level[i] && levels[i])
        lane_width[i] = lane_count[i];
      if (lane_count[i] > {1'b0, model_timeout}) begin
        lane_width[i] = '0;
        lane_count[i] = '0;
      end
      lane_level[i] = levels[i];
    end
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (lane_width[i] > best_w) begin
        best_w = lane_width[i];
        best_n = 3'(i + 1);
      end
      if (lane_width[i] == '0)
        all_nz = 1'b0;
      total = total + lane_width[i];
    end
    mean = total / NUM_SENSORS;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      d = (lane_width[i] >= mean) ? 64'(lane_width[i] - mean) : 64'(mean - lane_width[i]);
      acc = acc + d * d;
    end
    spread = 32'(acc / NUM_SENSORS);
    step   = spread / SPREAD_STEP;
    lim    = (model_limit > LIMIT_MAX) ? 32'(LIMIT_MAX) : 32'(model_limit);
    if (step > lim)
      step = lim;
    left  = lane_width[0] + lane_width[1];
    right = lane_width[2] + lane_width[3];
    r.sensor = best_n;
    r.width  = best_w;
    r.spread = spread[24:0];
    if (!all_nz || left == right)
      r.dir = CENTER;
    else if (left > right)
      r.dir = CENTER - 7'(step);
    else
      r.dir = CENTER + 7'(step);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        estimate_q.push_back(estimate_tick(in_tdata[3:0]));
      if (!in_tvalid || in_tready) begin
        if (tick_q.size() != 0 && $urandom_range(99, 0) >= send_idle) begin
          in_tdata  <= {4'b0000, tick_q.pop_front()};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (estimate_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: %h", out_tdata);
        end else begin
          want = estimate_q.pop_front();
          if (out_tdata[2:0] != want.sensor || out_tdata[15:3] != want.width ||
              out_tdata[40:16] != want.spread || out_tdata[47:41] != want.dir) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp sensor %0d width %0d spread %0d dir %0d, got %0d %0d %0d %0d",
                       want.sensor, want.width, want.spread, want.dir, out_tdata[2:0],
                       out_tdata[15:3], out_tdata[40:16], out_tdata[47:41]);
          end
        end
      end
      out_tready <= ($urandom_range(99, 0) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL ir_pulse_width_direction_estimator_core");
      $finish;
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [11:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TIMEOUT)
      model_timeout = val;
    else
      model_limit = val[5:0];
  endtask

  task automatic queue_ticks(input int n, input int max_low, input int max_high,
                             input int noise_pct);
    logic [3:0] lv;
    for (int t = 0; t < n; t++) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (gen_left[i] == 0) begin
          gen_level[i] = ~gen_level[i];
          gen_left[i]  = gen_level[i] ? $urandom_range(max_high, 1) : $urandom_range(max_low, 1);
        end
        gen_left[i]--;
        lv[i] = gen_level[i];
      end
      if ($urandom_range(99, 0) < noise_pct)
        lv = 4'($urandom_range(15, 0));
      tick_q.push_back(lv);
    end
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || in_tvalid || estimate_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_segment(input logic [11:0] timeout, input logic [11:0] limit, input int n,
                             input int max_low, input int max_high, input int noise_pct);
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_LIMIT, limit);
    queue_ticks(n, max_low, max_high, noise_pct);
    drain();
  endtask

  initial begin
    logic [3:0] directed [23];
    logic [11:0] rnd_to;
    directed = '{4'hF, 4'h0, 4'h0, 4'hF, 4'h0, 4'hE, 4'hC, 4'h8, 4'hF, 4'h0, 4'h7, 4'h3,
                 4'h1, 4'hF, 4'h0, 4'hA, 4'h5, 4'hF, 4'h5, 4'hA, 4'hF, 4'h0, 4'hF};
    model_timeout = TIMEOUT_RESET;
    model_limit   = LIMIT_RESET;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      lane_count[i] = '0;
      lane_width[i] = '0;
      lane_level[i] = 1'b1;
      gen_level[i]  = 1'b1;
      gen_left[i]   = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 17;
    recv_idle = 82;
    foreach (directed[k])
      tick_q.push_back(directed[k]);
    drain();
    run_segment(12'd870, 12'hFF2, 500, 450, 30, 5);
    run_segment(12'd4095, 12'hFFF, 150, 80, 10, 10);

    send_idle = 82;
    recv_idle = 17;
    run_segment(12'd1, 12'd0, 80, 3, 3, 10);
    run_segment(12'd0, 12'd51, 50, 3, 3, 10);
    rnd_to = 12'($urandom_range(60, 2));
    run_segment(rnd_to, 12'($urandom_range(4095, 0)), 120, rnd_to + 3, 8, 10);

    send_idle = 0;
    recv_idle = 0;
    repeat (2) begin
      rnd_to = 12'($urandom_range(60, 2));
      run_segment(rnd_to, 12'($urandom_range(4095, 0)), 110, rnd_to + 3, 8, 10);
    end

    if (mismatches == 0 && estimate_q.size() == 0)
      $display("PASS ir_pulse_width_direction_estimator_core");
    else
      $display("FAIL ir_pulse_width_direction_estimator_core");
    $finish;
  end

endmodule
